// ===== rtl/core/n23cfc_pkg.sv =====
// n23cfc_pkg: shared types and constants for the n23 credit flow control unit
// no dependencies; used by n23_credit_flow_control_unit
`timescale 1ns / 1ps
`default_nettype none

package n23cfc_pkg;

  localparam int unsigned CountWidth = 8;
  localparam int unsigned CfgWidth   = 8;
  localparam int unsigned OutBalWidth = 16;
  localparam int unsigned ApbDataWidth = 32;
  localparam int unsigned ApbAddrWidth = 3;

  typedef enum logic [1:0] {
    OP_POP    = 2'd0,
    OP_DATA   = 2'd1,
    OP_CREDIT = 2'd2
  } op_e;

  typedef enum logic {
    REG_CREDIT_BATCH = 1'b0,
    REG_CREDIT_EXTRA = 1'b1
  } reg_idx_e;

  localparam logic [CfgWidth-1:0] CreditBatchReset = 8'd10;
  localparam logic [CfgWidth-1:0] CreditExtraReset = 8'd20;

endpackage

`default_nettype wire

// ===== rtl/core/n23_credit_flow_control_unit.sv =====
// n23_credit_flow_control_unit: hop-by-hop n23 credit flow control for one circuit
// depends on n23cfc_pkg
`timescale 1ns / 1ps
`default_nettype none

// Takes one cell event word per clock and returns one result word for each, in the
// cycle after acceptance through a single output register; a new word is taken
// whenever that register is empty or being drained in the same cycle, so the
// sustained rate is one word per cycle. The balance, forwarded-count and blocked
// state for both directions sits in flip-flops and is updated at acceptance, so
// consecutive words see each other's effect with no stall. Registers: credit_batch
// at byte address 0, credit_extra at 4; writing either reloads both balances to
// credit_batch + credit_extra. No clearing pass is needed after reset.
module n23_credit_flow_control_unit #(
  parameter int unsigned BALANCE_WIDTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // apb configuration
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [n23cfc_pkg::ApbAddrWidth-1:0]   paddr,
  input  wire logic [n23cfc_pkg::ApbDataWidth-1:0]   pwdata,
  output logic      [n23cfc_pkg::ApbDataWidth-1:0]   prdata,
  output logic                                       pready,
  // input channel
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [1:0]                            operation_i,
  input  wire logic                                  direction_i,
  input  wire logic                                  cell_present_i,
  input  wire logic                                  peer_speaks_cells_i,
  // output channel
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic                                       send_credit_o,
  output logic                                       block_peer_o,
  output logic                                       unblock_link_o,
  output logic                                       credit_positive_o,
  output logic signed [n23cfc_pkg::OutBalWidth-1:0]  balance_now_o
);

  localparam int unsigned BW = BALANCE_WIDTH;
  localparam int unsigned CW = n23cfc_pkg::CfgWidth;
  localparam int unsigned NW = n23cfc_pkg::CountWidth;
  localparam int unsigned OW = n23cfc_pkg::OutBalWidth;

  logic [CW-1:0] credit_batch_q, credit_batch_d;
  logic [CW-1:0] credit_extra_q, credit_extra_d;
  logic signed [BW-1:0] credit_balance_q [2];
  logic signed [BW-1:0] credit_balance_d [2];
  logic [NW-1:0] forwarded_count_q [2];
  logic [NW-1:0] forwarded_count_d [2];
  logic [1:0] link_blocked_q, link_blocked_d;

  logic out_valid_q;
  logic send_credit_q, block_peer_q, unblock_link_q, credit_positive_q;
  logic signed [OW-1:0] balance_now_q;

  logic cfg_wr;
  logic in_acc;
  logic dir_own, dir_opp;
  n23cfc_pkg::op_e op;

  logic [CW:0] cap9;
  logic [CW:0] cap9_new;
  logic signed [BW-1:0] bal_min;
  logic signed [BW-1:0] bal_full_new;
  logic signed [BW-1:0] bal_dec;
  logic signed [BW:0] bal_sum;
  logic signed [BW:0] cap_ext;
  logic signed [BW-1:0] bal_credit;
  logic signed [BW-1:0] bal_res;
  logic [BW+OW-1:0] bal_res_ext;
  logic [NW:0] cnt_inc;
  logic [NW:0] cnt_next;
  logic cnt_due;
  logic send_w, block_w, unblock_w, positive_w;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign prdata  = (paddr[2] == n23cfc_pkg::REG_CREDIT_EXTRA)
                 ? {{(n23cfc_pkg::ApbDataWidth-CW){1'b0}}, credit_extra_q}
                 : {{(n23cfc_pkg::ApbDataWidth-CW){1'b0}}, credit_batch_q};

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_acc     = in_valid_i & in_ready_o;
  assign op         = n23cfc_pkg::op_e'(operation_i);
  assign dir_own    = direction_i;
  assign dir_opp    = ~direction_i;

  // configuration decode
  always_comb begin
    credit_batch_d = credit_batch_q;
    credit_extra_d = credit_extra_q;
    if (cfg_wr) begin
      unique case (n23cfc_pkg::reg_idx_e'(paddr[2]))
        n23cfc_pkg::REG_CREDIT_BATCH: credit_batch_d = pwdata[CW-1:0];
        n23cfc_pkg::REG_CREDIT_EXTRA: credit_extra_d = pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  assign cap9         = {1'b0, credit_batch_q} + {1'b0, credit_extra_q};
  assign cap9_new     = {1'b0, credit_batch_d} + {1'b0, credit_extra_d};
  assign bal_full_new = $signed({{(BW-CW-1){1'b0}}, cap9_new});
  assign bal_min      = $signed({1'b1, {(BW-1){1'b0}}});
  assign cap_ext      = $signed({{(BW-CW){1'b0}}, cap9});

  // data push: spend one credit, saturating at the bottom
  assign bal_dec = (credit_balance_q[dir_own] != bal_min)
                 ? credit_balance_q[dir_own] - BW'(1)
                 : credit_balance_q[dir_own];

  // credit push: refill the opposite balance, capped
  assign bal_sum    = $signed({credit_balance_q[dir_opp][BW-1], credit_balance_q[dir_opp]})
                    + $signed({{(BW+1-CW){1'b0}}, credit_batch_q});
  assign bal_credit = (bal_sum > cap_ext) ? cap_ext[BW-1:0] : bal_sum[BW-1:0];

  // pop: count forwarded cells
  assign cnt_inc  = {1'b0, forwarded_count_q[dir_own]} + (NW+1)'(1);
  assign cnt_due  = cnt_inc >= {1'b0, credit_batch_q};
  assign cnt_next = cnt_due ? cnt_inc - {1'b0, credit_batch_q} : cnt_inc;

  always_comb begin
    credit_balance_d  = credit_balance_q;
    forwarded_count_d = forwarded_count_q;
    link_blocked_d    = link_blocked_q;
    send_w     = 1'b0;
    block_w    = 1'b0;
    unblock_w  = 1'b0;
    positive_w = 1'b0;
    bal_res    = '0;
    case (op)
      n23cfc_pkg::OP_POP: begin
        if (cell_present_i) begin
          forwarded_count_d[dir_own] = cnt_next[NW-1:0];
          send_w = cnt_due & peer_speaks_cells_i;
        end
      end
      n23cfc_pkg::OP_DATA: begin
        credit_balance_d[dir_own] = bal_dec;
        bal_res = bal_dec;
        if ((bal_dec <= $signed(BW'(0))) && !peer_speaks_cells_i) begin
          link_blocked_d[dir_opp] = 1'b1;
          block_w = 1'b1;
        end
      end
      n23cfc_pkg::OP_CREDIT: begin
        credit_balance_d[dir_opp] = bal_credit;
        bal_res = bal_credit;
        if (bal_credit > $signed(BW'(0))) begin
          positive_w = 1'b1;
          if (link_blocked_q[dir_own]) begin
            link_blocked_d[dir_own] = 1'b0;
            unblock_w = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign bal_res_ext = {{OW{bal_res[BW-1]}}, bal_res};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_batch_q       <= n23cfc_pkg::CreditBatchReset;
      credit_extra_q       <= n23cfc_pkg::CreditExtraReset;
      credit_balance_q[0]  <= BW'(n23cfc_pkg::CreditBatchReset)
                            + BW'(n23cfc_pkg::CreditExtraReset);
      credit_balance_q[1]  <= BW'(n23cfc_pkg::CreditBatchReset)
                            + BW'(n23cfc_pkg::CreditExtraReset);
      forwarded_count_q[0] <= '0;
      forwarded_count_q[1] <= '0;
      link_blocked_q       <= '0;
      out_valid_q          <= 1'b0;
    end else begin
      credit_batch_q <= credit_batch_d;
      credit_extra_q <= credit_extra_d;
      if (cfg_wr) begin
        credit_balance_q[0] <= bal_full_new;
        credit_balance_q[1] <= bal_full_new;
      end else if (in_acc) begin
        credit_balance_q <= credit_balance_d;
      end
      if (in_acc) begin
        forwarded_count_q <= forwarded_count_d;
        link_blocked_q    <= link_blocked_d;
        out_valid_q       <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result word register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      send_credit_q     <= send_w;
      block_peer_q      <= block_w;
      unblock_link_q    <= unblock_w;
      credit_positive_q <= positive_w;
      balance_now_q     <= $signed(bal_res_ext[OW-1:0]);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign send_credit_o     = send_credit_q;
  assign block_peer_o      = block_peer_q;
  assign unblock_link_o    = unblock_link_q;
  assign credit_positive_o = credit_positive_q;
  assign balance_now_o     = balance_now_q;

  // balances never exceed the configured cap
  a_bal_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (credit_balance_q[0] <= cap_ext) && (credit_balance_q[1] <= cap_ext))
    else $error("balance above cap");

  // at most one of send_credit, block_peer and unblock_link per word
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0({send_credit_q, block_peer_q, unblock_link_q}))
    else $error("conflicting event flags");

  // unblocking only with a positive balance
  a_unblock_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && unblock_link_q) |-> credit_positive_q)
    else $error("unblock without positive balance");

  // an accepted word always yields a result next cycle
  a_acc_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("result word missing");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: randomized and directed check of the n23 credit flow control unit
// depends on n23cfc_pkg and n23_credit_flow_control_unit; an internal credit model
// predicts every result word, which is compared as it leaves the block
`timescale 1ns / 1ps

module testbench;

  localparam int BalWidth = 16;
  localparam int BalMin = -(2 ** (BalWidth - 1));
  localparam int CycleLimit = 1_000_000;
  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic       dir;
    logic       present;
    logic       peer;
  } cell_event_t;

  typedef struct packed {
    logic        send;
    logic        block;
    logic        unblock;
    logic        positive;
    logic [15:0] bal;
  } flow_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [n23cfc_pkg::ApbAddrWidth-1:0] paddr = '0;
  logic [n23cfc_pkg::ApbDataWidth-1:0] pwdata = '0;
  logic [n23cfc_pkg::ApbDataWidth-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] operation_i = '0;
  logic direction_i = 1'b0;
  logic cell_present_i = 1'b0;
  logic peer_speaks_cells_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic send_credit_o;
  logic block_peer_o;
  logic unblock_link_o;
  logic credit_positive_o;
  logic signed [n23cfc_pkg::OutBalWidth-1:0] balance_now_o;

  n23_credit_flow_control_unit #(
    .BALANCE_WIDTH(BalWidth)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .operation_i        (operation_i),
    .direction_i        (direction_i),
    .cell_present_i     (cell_present_i),
    .peer_speaks_cells_i(peer_speaks_cells_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .send_credit_o      (send_credit_o),
    .block_peer_o       (block_peer_o),
    .unblock_link_o     (unblock_link_o),
    .credit_positive_o  (credit_positive_o),
    .balance_now_o      (balance_now_o)
  );

  always #10 clk_i = ~clk_i;

  // credit model state
  logic [7:0] batch_q;
  logic [7:0] extra_q;
  int         bal_q [2];
  logic [7:0] fwd_q [2];
  logic       blocked_q [2];

  cell_event_t  cell_events [$];
  flow_result_t due_results [$];
  cell_event_t  cur_event;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int cycle_count = 0;
  int sent_count = 0;
  int checked_count = 0;

  function automatic flow_result_t credit_step(cell_event_t ev);
    flow_result_t r;
    logic other;
    int cnt;
    int cap;
    int b;
    r = '0;
    other = ~ev.dir;
    cap = int'(batch_q) + int'(extra_q);
    case (ev.op)
      n23cfc_pkg::OP_POP: begin
        if (ev.present) begin
          cnt = int'(fwd_q[ev.dir]) + 1;
          if (cnt >= int'(batch_q)) begin
            cnt = cnt - int'(batch_q);
            r.send = ev.peer;
          end
          fwd_q[ev.dir] = cnt[7:0];
        end
      end
      n23cfc_pkg::OP_DATA: begin
        if (bal_q[ev.dir] > BalMin) bal_q[ev.dir] = bal_q[ev.dir] - 1;
        r.bal = bal_q[ev.dir][15:0];
        if (bal_q[ev.dir] <= 0 && !ev.peer) begin
          blocked_q[other] = 1'b1;
          r.block = 1'b1;
        end
      end
      n23cfc_pkg::OP_CREDIT: begin
        b = bal_q[other] + int'(batch_q);
        if (b > cap) b = cap;
        bal_q[other] = b;
        r.bal = b[15:0];
        if (b > 0) begin
          r.positive = 1'b1;
          if (blocked_q[ev.dir]) begin
            blocked_q[ev.dir] = 1'b0;
            r.unblock = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin : drive_cells
    logic took;
    took = in_valid_i && in_ready_o;
    if (took) due_results.push_back(credit_step(cur_event));
    if (!in_valid_i || took) begin
      if (cell_events.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_event = cell_events.pop_front();
        sent_count++;
        in_valid_i <= 1'b1;
        operation_i <= cur_event.op;
        direction_i <= cur_event.dir;
        cell_present_i <= cur_event.present;
        peer_speaks_cells_i <= cur_event.peer;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : watch_results
    flow_result_t got;
    flow_result_t want;
    if (out_valid_o && out_ready_i) begin
      checked_count++;
      got = {send_credit_o, block_peer_o, unblock_link_o, credit_positive_o, balance_now_o};
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word send=%b block=%b unblock=%b pos=%b bal=%0d",
                 $time, got.send, got.block, got.unblock, got.positive, $signed(got.bal));
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected send=%b block=%b unblock=%b pos=%b bal=%0d",
                   $time, want.send, want.block, want.unblock, want.positive,
                   $signed(want.bal));
          $display("%0t:          actual send=%b block=%b unblock=%b pos=%b bal=%0d",
                   $time, got.send, got.block, got.unblock, got.positive, $signed(got.bal));
        end
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic void add_event(logic [1:0] op, logic dir, logic present, logic peer);
    cell_event_t ev;
    ev.op = op;
    ev.dir = dir;
    ev.present = present;
    ev.peer = peer;
    cell_events.push_back(ev);
  endfunction

  task automatic wait_drained();
    @(posedge clk_i);
    while (cell_events.size() > 0 || sent_count != checked_count) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input n23cfc_pkg::reg_idx_e idx, input logic [7:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == n23cfc_pkg::REG_CREDIT_BATCH) batch_q = val;
    else extra_q = val;
    bal_q[0] = int'(batch_q) + int'(extra_q);
    bal_q[1] = bal_q[0];
  endtask

  task automatic configure(input logic [7:0] batch, input logic [7:0] extra);
    write_reg(n23cfc_pkg::REG_CREDIT_BATCH, batch);
    write_reg(n23cfc_pkg::REG_CREDIT_EXTRA, extra);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_idle(input int mode);
    send_idle_pct = (mode == 1) ? 86 : (mode == 3) ? 25 : 0;
    recv_stall_pct = (mode == 2) ? 86 : (mode == 3) ? 25 : 0;
  endtask

  task automatic queue_random_events(input int count);
    int data_pct;
    int credit_pct;
    int dir_pct;
    int r;
    logic [1:0] op;
    data_pct = $urandom_range(20, 75);
    credit_pct = $urandom_range(5, 95 - data_pct);
    dir_pct = 10 + 40 * $urandom_range(0, 2);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2) op = OpUnused;
      else if (r < 2 + credit_pct) op = n23cfc_pkg::OP_CREDIT;
      else if (r < 2 + credit_pct + data_pct) op = n23cfc_pkg::OP_DATA;
      else op = n23cfc_pkg::OP_POP;
      add_event(op, $urandom_range(0, 99) < dir_pct, $urandom_range(0, 3) != 0,
                1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    batch_q = n23cfc_pkg::CreditBatchReset;
    extra_q = n23cfc_pkg::CreditExtraReset;
    bal_q[0] = int'(batch_q) + int'(extra_q);
    bal_q[1] = bal_q[0];
    fwd_q[0] = '0;
    fwd_q[1] = '0;
    blocked_q[0] = 1'b0;
    blocked_q[1] = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset values
    set_idle(0);
    add_event(n23cfc_pkg::OP_DATA, 1'b0, 1'b1, 1'b1);
    add_event(n23cfc_pkg::OP_CREDIT, 1'b1, 1'b0, 1'b0);
    add_event(n23cfc_pkg::OP_POP, 1'b0, 1'b0, 1'b1);
    wait_drained();

    // directed: credit batch, blocking, unblocking, unused code
    configure(8'd2, 8'd0);
    add_event(n23cfc_pkg::OP_POP, 1'b0, 1'b0, 1'b1);
    add_event(n23cfc_pkg::OP_POP, 1'b0, 1'b1, 1'b1);
    add_event(n23cfc_pkg::OP_POP, 1'b0, 1'b1, 1'b1);
    add_event(n23cfc_pkg::OP_POP, 1'b1, 1'b1, 1'b0);
    add_event(n23cfc_pkg::OP_POP, 1'b1, 1'b1, 1'b0);
    add_event(n23cfc_pkg::OP_DATA, 1'b0, 1'b0, 1'b0);
    add_event(n23cfc_pkg::OP_DATA, 1'b0, 1'b0, 1'b0);
    add_event(n23cfc_pkg::OP_DATA, 1'b0, 1'b1, 1'b0);
    add_event(n23cfc_pkg::OP_DATA, 1'b0, 1'b0, 1'b1);
    add_event(n23cfc_pkg::OP_CREDIT, 1'b1, 1'b0, 1'b0);
    add_event(n23cfc_pkg::OP_CREDIT, 1'b1, 1'b1, 1'b1);
    add_event(n23cfc_pkg::OP_CREDIT, 1'b1, 1'b0, 1'b0);
    add_event(OpUnused, 1'b1, 1'b1, 1'b1);
    add_event(OpUnused, 1'b0, 1'b0, 1'b0);
    add_event(n23cfc_pkg::OP_DATA, 1'b1, 1'b0, 1'b0);
    add_event(n23cfc_pkg::OP_DATA, 1'b1, 1'b0, 1'b0);
    add_event(n23cfc_pkg::OP_DATA, 1'b1, 1'b0, 1'b0);
    add_event(n23cfc_pkg::OP_CREDIT, 1'b0, 1'b1, 1'b1);
    add_event(n23cfc_pkg::OP_CREDIT, 1'b0, 1'b0, 1'b1);
    wait_drained();

    // count above a lowered batch
    configure(8'd255, 8'd255);
    for (int i = 0; i < 200; i++) add_event(n23cfc_pkg::OP_POP, 1'b0, 1'b1, 1'b1);
    for (int i = 0; i < 60; i++)
      add_event(n23cfc_pkg::OP_POP, 1'b1, 1'b1, 1'($urandom_range(0, 1)));
    wait_drained();
    configure(8'd5, 8'd0);
    for (int i = 0; i < 45; i++) add_event(n23cfc_pkg::OP_POP, 1'b0, 1'b1, 1'b1);
    for (int i = 0; i < 15; i++)
      add_event(n23cfc_pkg::OP_POP, 1'b1, 1'b1, 1'($urandom_range(0, 1)));
    wait_drained();

    // zero batch: every pop is due and sends when the peer speaks cells
    configure(8'd0, 8'd3);
    for (int i = 0; i < 300; i++)
      add_event(n23cfc_pkg::OP_POP, $urandom_range(0, 3) == 0, 1'b1,
                1'($urandom_range(0, 1)));
    for (int i = 0; i < 10; i++) add_event(n23cfc_pkg::OP_DATA, 1'b1, 1'b1, 1'b0);
    add_event(n23cfc_pkg::OP_CREDIT, 1'b0, 1'b1, 1'b1);
    wait_drained();
    configure(8'd0, 8'd0);
    add_event(n23cfc_pkg::OP_DATA, 1'b0, 1'b0, 1'b0);
    add_event(n23cfc_pkg::OP_CREDIT, 1'b1, 1'b0, 1'b0);
    add_event(n23cfc_pkg::OP_POP, 1'b1, 1'b1, 1'b1);
    wait_drained();

    // random segments
    for (int seg = 0; seg < 8; seg++) begin
      case (seg)
        0: configure(8'd1, 8'd0);
        1: configure(8'd255, 8'd255);
        2: configure(8'd1, 8'd255);
        3: configure(8'd255, 8'd0);
        default: configure(8'($urandom_range(1, 12)), 8'($urandom_range(0, 40)));
      endcase
      set_idle(seg % 4);
      queue_random_events(150);
      wait_drained();
    end

    // deep negative balance
    set_idle(0);
    configure(8'd1, 8'd0);
    for (int i = 0; i < 80; i++)
      add_event(n23cfc_pkg::OP_DATA, 1'b0, 1'($urandom_range(0, 1)),
                $urandom_range(0, 9) != 0);
    add_event(n23cfc_pkg::OP_CREDIT, 1'b1, 1'b0, 1'b0);
    add_event(n23cfc_pkg::OP_DATA, 1'b0, 1'b1, 1'b0);
    add_event(n23cfc_pkg::OP_CREDIT, 1'b1, 1'b1, 1'b1);
    wait_drained();

    repeat (5) @(posedge clk_i);
    if (due_results.size() > 0) begin
      errors++;
      $display("%0t: %0d expected words never arrived", $time, due_results.size());
    end
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
